### sv/sparse_set_engine_assert.svh
// Assertion macros for the sparse set engine.
// Each macro samples on clock and is disabled while reset is high.
`ifndef SPARSE_SET_ENGINE_ASSERT_SVH
`define SPARSE_SET_ENGINE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SSE_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SSE_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/sse_pkg.sv
// Shared types and field widths of the sparse set engine.
// No dependencies; used by the channel interfaces and the top level.
package sse_pkg;

   localparam int CMD_W = 4;
   localparam int ELT_W = 8;
   localparam int CNT_W = 9;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD      = 4'd0,
      CMD_REMOVE   = 4'd1,
      CMD_CONTAINS = 4'd2,
      CMD_NEXT     = 4'd3,
      CMD_PREV     = 4'd4,
      CMD_READ     = 4'd5,
      CMD_FILL     = 4'd6,
      CMD_CLEAR    = 4'd7,
      CMD_POP_BACK = 4'd8,
      CMD_POP_HEAD = 4'd9,
      CMD_MOVE_UP  = 4'd10,
      CMD_BACK     = 4'd11
   } cmd_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOK,
      ST_EXEC,
      ST_WR2,
      ST_FIN
   } state_type;

endpackage

### sv/sse_req_if.sv
// Command channel of the sparse set engine: valid/ready plus command payload.
// Depends on sse_pkg for field widths.
interface sse_req_if import sse_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CMD_W-1:0] cmd;
   logic [ELT_W-1:0] elt;
   logic [ELT_W-1:0] position;

   modport source (output valid, output cmd, output elt, output position, input ready);
   modport sink   (input valid, input cmd, input elt, input position, output ready);
endinterface

### sv/sse_rsp_if.sv
// Result channel of the sparse set engine: valid/ready plus result payload.
// Depends on sse_pkg for field widths.
interface sse_rsp_if import sse_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             found;
   logic [ELT_W-1:0] value;
   logic [CNT_W-1:0] count;
   logic             is_empty;

   modport source (output valid, output found, output value, output count,
                   output is_empty, input ready);
   modport sink   (input valid, input found, input value, input count,
                   input is_empty, output ready);
endinterface

### sv/sparse_set_engine.sv
// Sparse set engine: a set over the elements 0..UNIVERSE-1 kept as a
// permutation (order RAM) and its inverse (position RAM); the first
// count entries of the permutation are the members.
//
// Channels: req_bus carries one command beat (cmd, elt, position);
// rsp_bus returns exactly one result beat per command (found, value,
// count, is_empty), in command order. Both use valid/ready.
//
// Sequence: both RAMs are read as a command is accepted; in LOOK their
// beats arrive and the order RAM is read a second time; EXEC updates the
// count and writes the first half of a swap; WR2 writes the second half.
// The result register is loaded in WR2, or in FIN when there is no swap
// or the register is still full. The single write port of each RAM splits
// the swap in two. A new command is taken only in idle, once the last is done.
//
// Reset: synchronous, active high. Afterwards a clearing pass writes the
// identity permutation into both RAMs, one entry a cycle; req_bus.ready
// stays low during the pass.
//
// Stall: the result register holds its beat until rsp_bus.ready; a new
// command is still accepted meanwhile, and its own result waits for the
// register to drain before the engine returns to idle.
`include "sparse_set_engine_assert.svh"

module sparse_set_engine import sse_pkg::*; #(
   parameter int UNIVERSE = 256
) (
   input logic      clock,
   input logic      reset,
   sse_req_if.sink  req_bus,
   sse_rsp_if.source rsp_bus
);
   localparam int AW   = $clog2(UNIVERSE);
   localparam int CNW  = $clog2(UNIVERSE + 1);
   localparam int XW   = (AW > ELT_W) ? AW : ELT_W;
   localparam int XW1  = XW + 1;
   localparam int KW   = (CNW > CNT_W) ? CNW : CNT_W;
   localparam logic [CNW-1:0] CNT_MAX  = CNW'(UNIVERSE);
   localparam logic [XW1-1:0] UNIV_X   = XW1'(UNIVERSE);
   localparam logic [AW-1:0]  LAST_IDX = AW'(UNIVERSE - 1);

   // control state
   state_type        state_ff, state_in;
   logic [AW-1:0]    clr_ff, clr_in;
   logic [CNW-1:0]   cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // command and working registers (payload, no reset)
   cmd_type          cmd_ff;
   logic [ELT_W-1:0] elt_ff;
   logic [ELT_W-1:0] pos_ff;
   logic [AW-1:0]    p_ff;
   logic [AW-1:0]    oa_ff;
   logic             member_ff;
   logic [AW-1:0]    ea_ff;
   logic [AW-1:0]    pb_ff;
   logic [ELT_W-1:0] val_ff;
   logic             found_ff;
   logic             rsp_found_ff;
   logic [ELT_W-1:0] rsp_value_ff;
   logic [CNT_W-1:0] rsp_count_ff;
   logic             rsp_empty_ff;

   // RAM ports
   logic             ord_we, pof_we;
   logic [AW-1:0]    ord_waddr, ord_wdata, ord_raddr, ord_rdata;
   logic [AW-1:0]    pof_waddr, pof_wdata, pof_raddr, pof_rdata;

   // request side decode
   cmd_type          req_cmd;
   logic [XW-1:0]    req_elt_x, req_pos_x;
   logic [CNW-1:0]   cnt_m1;
   logic [AW-1:0]    cnt_a, cnt_m1_a, req_addr_a;

   // command side decode
   logic [XW-1:0]    elt_x, pos_x;
   logic [AW-1:0]    elt_a, pos_a;
   logic             elt_inr, pos_inr;
   logic             look_member;
   logic [AW-1:0]    look_addr_b;

   // execute step results
   logic             do_swap;
   logic [AW-1:0]    ex_pa, ex_pb, ex_ea, ex_eb, ex_fpos;
   logic [CNW-1:0]   ex_cnt;
   logic [ELT_W-1:0] ex_val;
   logic             ex_found;

   logic             req_fire, rsp_free, rsp_load;
   logic [KW-1:0]    cnt_k;

   sse_ram #(.WIDTH(AW), .DEPTH(UNIVERSE)) u_order (
      .clock (clock),
      .we    (ord_we),
      .waddr (ord_waddr),
      .wdata (ord_wdata),
      .raddr (ord_raddr),
      .rdata (ord_rdata)
   );

   sse_ram #(.WIDTH(AW), .DEPTH(UNIVERSE)) u_posof (
      .clock (clock),
      .we    (pof_we),
      .waddr (pof_waddr),
      .wdata (pof_wdata),
      .raddr (pof_raddr),
      .rdata (pof_rdata)
   );

   // ---------------------------------------------------------------
   // Decode of the incoming beat and of the latched command
   // ---------------------------------------------------------------
   assign req_cmd   = cmd_type'(req_bus.cmd);
   assign req_elt_x = XW'(req_bus.elt);
   assign req_pos_x = XW'(req_bus.position);
   assign cnt_m1    = cnt_ff - CNW'(1);
   assign cnt_a     = cnt_ff[AW-1:0];
   assign cnt_m1_a  = cnt_m1[AW-1:0];

   // First order RAM read: the slot the command swaps with or returns.
   always_comb begin
      case (req_cmd)
         CMD_ADD:                req_addr_a = cnt_a;
         CMD_REMOVE, CMD_BACK:   req_addr_a = cnt_m1_a;
         CMD_POP_HEAD:           req_addr_a = '0;
         CMD_MOVE_UP, CMD_READ:  req_addr_a = req_pos_x[AW-1:0];
         default:                req_addr_a = cnt_a;
      endcase
   end

   assign elt_x   = XW'(elt_ff);
   assign pos_x   = XW'(pos_ff);
   assign elt_a   = elt_x[AW-1:0];
   assign pos_a   = pos_x[AW-1:0];
   assign elt_inr = {1'b0, elt_x} < UNIV_X;
   assign pos_inr = {1'b0, pos_x} < UNIV_X;

   // Membership from the position RAM beat that arrives in the look step.
   assign look_member = elt_inr && (CNW'(pof_rdata) < cnt_ff);

   // Second order RAM read: the neighbor or the last member.
   always_comb begin
      case (cmd_ff)
         CMD_PREV:     look_addr_b = pof_rdata - AW'(1);
         CMD_POP_HEAD: look_addr_b = cnt_m1_a;
         default:      look_addr_b = pof_rdata + AW'(1);
      endcase
   end

   // ---------------------------------------------------------------
   // Execute step: decide the swap, the new count and the result.
   // The swap writes order[pa] = eb, posof[eb] = pa first, then
   // order[pb] = ea, posof[ea] = pb, so the later write wins on overlap.
   // ---------------------------------------------------------------
   always_comb begin
      do_swap = 1'b0;
      ex_pa   = p_ff;
      ex_pb   = p_ff;
      ex_ea   = elt_a;
      ex_eb   = oa_ff;
      ex_cnt  = cnt_ff;
      ex_val  = '0;
      case (cmd_ff)
         CMD_ADD: begin
            if (elt_inr && !member_ff) begin
               do_swap = 1'b1;
               ex_pb   = cnt_a;
               ex_cnt  = cnt_ff + CNW'(1);
            end
         end
         CMD_REMOVE: begin
            if (member_ff) begin
               do_swap = 1'b1;
               ex_pb   = cnt_m1_a;
               ex_cnt  = cnt_m1;
            end
         end
         CMD_NEXT: begin
            ex_val = elt_ff;
            if (member_ff && ((CNW'(p_ff) + CNW'(1)) < cnt_ff)) begin
               ex_val = ELT_W'(ord_rdata);
            end
         end
         CMD_PREV: begin
            ex_val = elt_ff;
            if (member_ff && (p_ff != '0)) begin
               ex_val = ELT_W'(ord_rdata);
            end
         end
         CMD_READ: begin
            if (pos_inr) begin
               ex_val = ELT_W'(oa_ff);
            end
         end
         CMD_FILL:  ex_cnt = CNT_MAX;
         CMD_CLEAR: ex_cnt = '0;
         CMD_POP_BACK: begin
            if (cnt_ff != '0) begin
               ex_cnt = cnt_m1;
            end
         end
         CMD_POP_HEAD: begin
            if (cnt_ff != '0) begin
               do_swap = 1'b1;
               ex_pa   = '0;
               ex_ea   = oa_ff;
               ex_pb   = cnt_m1_a;
               ex_eb   = ord_rdata;
               ex_cnt  = cnt_m1;
            end
         end
         CMD_MOVE_UP: begin
            if (elt_inr && pos_inr && (XW'(p_ff) <= pos_x)) begin
               do_swap = 1'b1;
               ex_pb   = pos_a;
            end
         end
         CMD_BACK: begin
            if (cnt_ff != '0) begin
               ex_val = ELT_W'(oa_ff);
            end
         end
         default: begin
            ex_val = '0;
         end
      endcase

      // position of elt once the swap has landed
      ex_fpos = p_ff;
      if (do_swap) begin
         if (elt_a == ex_ea) begin
            ex_fpos = ex_pb;
         end else if (elt_a == ex_eb) begin
            ex_fpos = ex_pa;
         end
      end
      ex_found = elt_inr && (CNW'(ex_fpos) < ex_cnt);
   end

   // ---------------------------------------------------------------
   // Sequencer: next state, RAM ports, result load
   // ---------------------------------------------------------------
   assign req_fire = req_bus.valid && req_bus.ready;
   assign rsp_free = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      req_bus.ready  = 1'b0;
      rsp_load       = 1'b0;
      ord_we         = 1'b0;
      ord_waddr      = ex_pa;
      ord_wdata      = ex_eb;
      ord_raddr      = req_addr_a;
      pof_we         = 1'b0;
      pof_waddr      = ex_eb;
      pof_wdata      = ex_pa;
      pof_raddr      = req_elt_x[AW-1:0];
      case (state_ff)
         ST_CLEAR: begin
            // write the identity permutation into both RAMs
            ord_we    = 1'b1;
            ord_waddr = clr_ff;
            ord_wdata = clr_ff;
            pof_we    = 1'b1;
            pof_waddr = clr_ff;
            pof_wdata = clr_ff;
            clr_in    = clr_ff + AW'(1);
            if (clr_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_bus.ready = 1'b1;
            if (req_fire) begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            ord_raddr = look_addr_b;
            state_in  = ST_EXEC;
         end
         ST_EXEC: begin
            if (do_swap) begin
               ord_we   = 1'b1;
               pof_we   = 1'b1;
               state_in = ST_WR2;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_WR2: begin
            ord_we    = 1'b1;
            ord_waddr = pb_ff;
            ord_wdata = ea_ff;
            pof_we    = 1'b1;
            pof_waddr = ea_ff;
            pof_wdata = pb_ff;
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (state_ff == ST_EXEC) begin
         cnt_in = ex_cnt;
      end
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign cnt_k = KW'(cnt_ff);

   // ---------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      // latch the command beat
      if (req_fire) begin
         cmd_ff <= req_cmd;
         elt_ff <= req_bus.elt;
         pos_ff <= req_bus.position;
      end
      // hold the first RAM beats for the execute step
      if (state_ff == ST_LOOK) begin
         p_ff      <= pof_rdata;
         oa_ff     <= ord_rdata;
         member_ff <= look_member;
      end
      // keep the second half of the swap and the result
      if (state_ff == ST_EXEC) begin
         ea_ff    <= ex_ea;
         pb_ff    <= ex_pb;
         val_ff   <= ex_val;
         found_ff <= ex_found;
      end
      if (rsp_load) begin
         rsp_found_ff <= found_ff;
         rsp_value_ff <= val_ff;
         rsp_count_ff <= cnt_k[CNT_W-1:0];
         rsp_empty_ff <= (cnt_ff == '0);
      end
   end

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.found    = rsp_found_ff;
   assign rsp_bus.value    = rsp_value_ff;
   assign rsp_bus.count    = rsp_count_ff;
   assign rsp_bus.is_empty = rsp_empty_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   `SSE_ASSERT_SAME(a_count_range, 1'b1, cnt_ff <= CNT_MAX, "member count above universe")
   `SSE_ASSERT_NEXT(a_swap_pair, (state_ff == ST_EXEC) && do_swap, state_ff == ST_WR2, "swap lost its second write")
   `SSE_ASSERT_SAME(a_load_free, rsp_load, !rsp_valid_ff || rsp_bus.ready, "result overwrote a pending beat")
   `SSE_ASSERT_NEXT(a_accept_look, req_fire, state_ff == ST_LOOK, "accepted beat did not start a lookup")

endmodule

### sv/sse_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module sse_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

### tb/sv/sse_set_checker.sv
// Result checker for the sparse set engine. It keeps its own copy of the
// permutation, the inverse and the member count, and checks result beats in order.
// Depends on sse_pkg and the sse_req_if / sse_rsp_if channel interfaces.
module sse_set_checker import sse_pkg::*; (
   input  logic clock,
   input  logic reset,
   sse_req_if   req_mon,
   sse_rsp_if   rsp_mon,
   output int   mismatches,
   output int   pending,
   output int   checked
);
   timeunit 1ns;
   timeprecision 1ps;

   // 8-bit elements and positions always fall inside a 256-entry universe.
   localparam int UNIVERSE = 256;

   typedef struct packed {
      cmd_type          cmd;
      logic [ELT_W-1:0] elt;
      logic             found;
      logic [ELT_W-1:0] value;
      logic [CNT_W-1:0] count;
      logic             is_empty;
   } set_result_type;

   logic [ELT_W-1:0] perm    [UNIVERSE];
   logic [ELT_W-1:0] slot_of [UNIVERSE];
   int unsigned      members;
   set_result_type   pending_results [$];

   function automatic bit holds(logic [ELT_W-1:0] e);
      return slot_of[e] < members;
   endfunction

   // Swap two permutation entries and keep the inverse in step.
   function automatic void exchange(int unsigned a, int unsigned b);
      logic [ELT_W-1:0] ea;
      logic [ELT_W-1:0] eb;
      ea = perm[a];
      eb = perm[b];
      perm[a] = eb;
      perm[b] = ea;
      slot_of[eb] = ELT_W'(a);
      slot_of[ea] = ELT_W'(b);
   endfunction

   function automatic set_result_type apply_command(cmd_type c, logic [ELT_W-1:0] e,
                                                    logic [ELT_W-1:0] p);
      set_result_type r;
      int unsigned at;
      r.cmd   = c;
      r.elt   = e;
      r.value = '0;
      at      = slot_of[e];
      case (c)
         CMD_ADD: begin
            if (!holds(e)) begin
               exchange(at, members);
               members++;
            end
         end
         CMD_REMOVE: begin
            if (holds(e)) begin
               members--;
               exchange(at, members);
            end
         end
         CMD_NEXT: begin
            r.value = e;
            if (holds(e) && at + 1 < members) r.value = perm[at + 1];
         end
         CMD_PREV: begin
            r.value = e;
            if (holds(e) && at > 0) r.value = perm[at - 1];
         end
         CMD_READ:     r.value = perm[p];
         CMD_FILL:     members = UNIVERSE;
         CMD_CLEAR:    members = 0;
         CMD_POP_BACK: if (members > 0) members--;
         CMD_POP_HEAD: begin
            if (members > 0) begin
               members--;
               exchange(0, members);
            end
         end
         CMD_MOVE_UP:  if (at <= p) exchange(at, p);
         CMD_BACK:     if (members > 0) r.value = perm[members - 1];
         default: ;
      endcase
      r.found    = holds(e);
      r.count    = CNT_W'(members);
      r.is_empty = (members == 0);
      return r;
   endfunction

   always @(posedge clock) begin
      set_result_type want;
      if (reset) begin
         for (int i = 0; i < UNIVERSE; i++) begin
            perm[i]    = ELT_W'(i);
            slot_of[i] = ELT_W'(i);
         end
         members = 0;
         pending_results.delete();
         mismatches = 0;
         checked = 0;
      end else begin
         // A result beat can never belong to a command taken at the same edge.
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pending_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%t: result beat with no command waiting", $realtime);
            end else begin
               want = pending_results.pop_front();
               checked++;
               if (rsp_mon.found !== want.found || rsp_mon.value !== want.value ||
                   rsp_mon.count !== want.count || rsp_mon.is_empty !== want.is_empty) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%t: cmd %0d elt %0d found/value/count/empty exp %b %0d %0d %b got %b %0d %0d %b",
                              $realtime, want.cmd, want.elt, want.found, want.value,
                              want.count, want.is_empty, rsp_mon.found, rsp_mon.value,
                              rsp_mon.count, rsp_mon.is_empty);
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            pending_results.insert(pending_results.size(),
                                   apply_command(cmd_type'(req_mon.cmd), req_mon.elt,
                                                 req_mon.position));
      end
      pending = pending_results.size();
   end

endmodule

### tb/sv/tb_top.sv
// Top of the sparse set engine testbench: clock, reset, command stimulus,
// result back-pressure and the verdict. Depends on sse_pkg, the channel
// interfaces, the engine itself and sse_set_checker.
module tb_top import sse_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ELT_MAX         = (1 << ELT_W) - 1;
   localparam int RANDOM_BEATS    = 1500;
   localparam int HOLD_OFF_CYCLES = 100;
   localparam int SETTLE_CYCLES   = 20;

   logic clock = 1'b0;
   logic reset = 1'b1;

   int mismatches;
   int pending;
   int checked;

   // hold_requests is shared between the stimulus and the result sink.
   int hold_requests = 0;  // bumped by the stimulus, served by the sink
   int burst_left    = 0;  // beats still to send back to back
   int beats_sent    = 0;

   sse_req_if req_bus ();
   sse_rsp_if rsp_bus ();

   sparse_set_engine #(.UNIVERSE(256)) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   sse_set_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_bus),
      .rsp_mon    (rsp_bus),
      .mismatches (mismatches),
      .pending    (pending),
      .checked    (checked)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   // Offer one command beat at a falling edge and hold it until accepted.
   // Returns at the falling edge after the accepting rising edge.
   task automatic send_beat(input cmd_type c, input logic [ELT_W-1:0] e,
                            input logic [ELT_W-1:0] p);
      int gap;
      if (burst_left > 0) begin
         gap = 0;
         burst_left--;
      end else begin
         gap = pick_gap();
      end
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.cmd      <= c;
      req_bus.elt      <= e;
      req_bus.position <= p;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      @(negedge clock);
      beats_sent++;
   endtask

   // Drop valid and wait until every result beat in flight has come back.
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
   endtask

   // Weighted command mix: adds outrun removals, while clear and fill keep
   // resetting the size, so the set sweeps from empty to full and back.
   // Elements lean on two small pools so lookups hit members often.
   task automatic send_random_beat();
      int roll;
      cmd_type c;
      logic [ELT_W-1:0] e;
      logic [ELT_W-1:0] p;
      roll = $urandom_range(0, 99);
      if      (roll < 28) c = CMD_ADD;
      else if (roll < 40) c = CMD_REMOVE;
      else if (roll < 48) c = CMD_CONTAINS;
      else if (roll < 56) c = CMD_NEXT;
      else if (roll < 64) c = CMD_PREV;
      else if (roll < 72) c = CMD_READ;
      else if (roll < 73) c = CMD_FILL;
      else if (roll < 75) c = CMD_CLEAR;
      else if (roll < 80) c = CMD_POP_BACK;
      else if (roll < 85) c = CMD_POP_HEAD;
      else if (roll < 94) c = CMD_MOVE_UP;
      else                c = CMD_BACK;
      roll = $urandom_range(0, 99);
      if      (roll < 40) e = ELT_W'($urandom_range(0, ELT_MAX));
      else if (roll < 75) e = ELT_W'($urandom_range(0, 15));
      else                e = ELT_W'($urandom_range(ELT_MAX - 15, ELT_MAX));
      if ($urandom_range(0, 99) < 60) p = ELT_W'($urandom_range(0, ELT_MAX));
      else                            p = ELT_W'($urandom_range(0, 15));
      send_beat(c, e, p);
   endtask

   // Result side: ready toggles in random stretches; a hold request from the
   // stimulus forces ready low for a whole hold-off stretch.
   initial begin : result_sink
      int run_left;
      int idle_left;
      int holds_served;
      run_left      = 0;
      idle_left     = 0;
      holds_served  = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (holds_served != hold_requests) begin
            holds_served = hold_requests;
            run_left     = 0;
            idle_left    = HOLD_OFF_CYCLES;
         end
         if (run_left > 0) begin
            rsp_bus.ready <= 1'b1;
            run_left--;
         end else if (idle_left > 0) begin
            rsp_bus.ready <= 1'b0;
            idle_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
            // Now and then a long stretch with no stall at all.
            run_left  = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                    : $urandom_range(0, 3);
            idle_left = pick_gap();
         end
      end
   end

   initial begin : stimulus
      req_bus.valid    = 1'b0;
      req_bus.cmd      = CMD_CONTAINS;
      req_bus.elt      = '0;
      req_bus.position = '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // Directed part. The engine clears its RAMs first; ready holds us off.
      // Empty set: lookups miss, back reads zero, both pops do nothing.
      send_beat(CMD_CONTAINS, 8'd0,   8'd0);
      send_beat(CMD_BACK,     8'd0,   8'd0);
      send_beat(CMD_POP_BACK, 8'd0,   8'd0);
      send_beat(CMD_POP_HEAD, 8'd0,   8'd0);
      // Build the order 0, 255, 170; the second add of 0 must change nothing.
      send_beat(CMD_ADD,      8'd0,   8'd0);
      send_beat(CMD_ADD,      8'd255, 8'd0);
      send_beat(CMD_ADD,      8'd0,   8'd0);
      send_beat(CMD_ADD,      8'd170, 8'd0);
      // Walk the order, including both ends and a non-member.
      send_beat(CMD_NEXT,     8'd0,   8'd0);
      send_beat(CMD_NEXT,     8'd170, 8'd0);
      send_beat(CMD_PREV,     8'd0,   8'd0);
      send_beat(CMD_PREV,     8'd170, 8'd0);
      send_beat(CMD_NEXT,     8'd5,   8'd0);
      // Read a slot past the members: returns whatever the permutation holds.
      send_beat(CMD_READ,     8'd0,   8'd255);
      send_beat(CMD_REMOVE,   8'd77,  8'd0);
      // Move up: downward target ignored, then a move across the boundary,
      // then a move onto the element's own slot.
      send_beat(CMD_MOVE_UP,  8'd170, 8'd0);
      send_beat(CMD_MOVE_UP,  8'd0,   8'd255);
      send_beat(CMD_MOVE_UP,  8'd7,   8'd7);
      send_beat(CMD_REMOVE,   8'd255, 8'd0);
      send_beat(CMD_BACK,     8'd0,   8'd0);
      send_beat(CMD_POP_HEAD, 8'd0,   8'd0);
      // Full universe: back reads the last slot, then shrink and empty.
      send_beat(CMD_FILL,     8'd0,   8'd0);
      send_beat(CMD_BACK,     8'd0,   8'd0);
      send_beat(CMD_POP_BACK, 8'd255, 8'd0);
      send_beat(CMD_CLEAR,    8'd9,   8'd0);

      // Pause the sender until the engine has answered everything.
      drain_results();

      for (int n = 0; n < RANDOM_BEATS; n++) begin
         // Long result hold-off with commands sent back to back: the
         // engine fills up and has to stall its input.
         if (n == RANDOM_BEATS / 3) begin
            hold_requests++;
            burst_left = 16;
         end
         if (n == 2 * RANDOM_BEATS / 3) drain_results();
         if (burst_left == 0 && $urandom_range(0, 49) == 0)
            burst_left = $urandom_range(20, 60);
         send_random_beat();
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
      $display("Run covered %0d command beats of all twelve kinds, incl. full fill,",
               beats_sent);
      $display("a long result hold-off and idle pauses; %0d results checked, %0d mismatches.",
               checked, mismatches);
      if (mismatches == 0 && pending == 0) begin
         $display("sparse_set_engine test passed");
      end else begin
         $display("sparse_set_engine test failed");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin : watchdog
      #2_000_000;
      $display("sparse_set_engine test failed");
      $finish;
   end

endmodule

### sim.f
+incdir+sv
sv/sse_pkg.sv
sv/sse_req_if.sv
sv/sse_rsp_if.sv
sv/sse_ram.sv
sv/sparse_set_engine.sv
tb/sv/sse_set_checker.sv
tb/sv/tb_top.sv
